@@ rtl/core/delimiter_string_splitter_assert.svh @@
// Assertion macros for the delimiter string splitter.
// Depends on clk and rst being visible where a macro is used.
`ifndef DELIMITER_STRING_SPLITTER_ASSERT_SVH
`define DELIMITER_STRING_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define DSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dss assertion failed");

// Next-cycle implication, disabled in reset.
`define DSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dss assertion failed");

`endif

@@ rtl/core/dss_pkg.sv @@
// Shared types and constants for the delimiter string splitter.
// No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

  localparam int MAX_DELIM   = 8;
  localparam int MAX_STRING  = 65536;
  localparam int POS_W       = 17;
  localparam int DLEN_W      = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       empty_string;
  } src_word_t;

  typedef struct packed {
    logic [POS_W-1:0] segment_start;
    logic [POS_W-1:0] segment_length;
    logic             last_segment;
    logic             too_long;
  } seg_word_t;

  typedef struct packed {
    logic      two;
    seg_word_t first;
    seg_word_t second;
  } dss_entry_t;

endpackage

@@ rtl/core/delimiter_string_splitter.sv @@
// Delimiter string splitter: one string byte per word in, one segment per word out.
// Takes one byte per cycle while the queue is not full; a byte is compared against the
// whole delimiter window in the cycle it is accepted. Results leave one per cycle
// from an output register, fed from the queue, while the output is not stalled.
// A delimiter match on a string's last byte gives two results, so such a byte
// occupies the output for two result words; a four-entry queue between the matcher and
// the output register absorbs these and output stalls. Registers are written
// through the cfg port, which is always ready; write them only while idle.
// Depends on dss_pkg, dss_front, dss_queue and dss_back.
`timescale 1ns / 1ps

module delimiter_string_splitter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               src_valid,
  output logic                               src_stall,
  input  dss_pkg::src_word_t                 src_word,
  output logic                               seg_valid,
  input  logic                               seg_stall,
  output dss_pkg::seg_word_t                 seg_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [8*dss_pkg::MAX_DELIM-1:0]    cfg_data
);
  import dss_pkg::*;

  logic [DLEN_W-1:0]      delim_length;
  logic [8*MAX_DELIM-1:0] delim_bytes;
  logic                   q_full;
  logic                   q_push;
  dss_entry_t             q_in;
  logic                   q_pop;
  logic                   q_avail;
  dss_entry_t             q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_length <= '0;
      delim_bytes  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELIM_LENGTH: delim_length <= cfg_data[DLEN_W-1:0];
        REG_DELIM_BYTES:  delim_bytes  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dss_front u_front (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .src_word     (src_word),
    .delim_length (delim_length),
    .delim_bytes  (delim_bytes),
    .full         (q_full),
    .push         (q_push),
    .entry        (q_in)
  );

  dss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .avail      (q_avail),
    .head_entry (q_head)
  );

  dss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (q_avail),
    .head_entry (q_head),
    .pop        (q_pop),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg_word   (seg_word)
  );

endmodule

@@ rtl/core/dss_front.sv @@
// Front end: accepts bytes, keeps the window and position, detects matches.
// Pushes one entry of one or two results per result-bearing byte. Uses dss_pkg.
`timescale 1ns / 1ps

module dss_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         src_valid,
  output logic                         src_stall,
  input  dss_pkg::src_word_t           src_word,
  input  logic [dss_pkg::DLEN_W-1:0]   delim_length,
  input  logic [8*dss_pkg::MAX_DELIM-1:0] delim_bytes,
  input  logic                         full,
  output logic                         push,
  output dss_pkg::dss_entry_t          entry
);
  import dss_pkg::*;

  logic [7:0]        win [MAX_DELIM];
  logic [7:0]        win_next [MAX_DELIM];
  logic [7:0]        dbyte [MAX_DELIM];
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  seg;
  logic              ovf;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  seg_next;
  logic              ovf_next;
  logic              accept;
  logic              saturated;
  logic [DLEN_W-1:0] d;
  logic [MAX_DELIM-1:0] hit;
  logic              covered;
  logic              match_hit;
  logic [POS_W-1:0]  pos_inc;
  logic [DLEN_W-1:0] want_idx [MAX_DELIM];
  seg_word_t         r_match;
  seg_word_t         r_last;
  seg_word_t         r_empty;

  assign src_stall = full;
  assign accept    = src_valid && !full;
  assign saturated = (pos >= POS_W'(MAX_STRING));
  assign d         = (delim_length > DLEN_W'(MAX_DELIM)) ? DLEN_W'(MAX_DELIM) : delim_length;
  assign pos_inc   = pos + POS_W'(1);
  assign covered   = ({1'b0, pos_inc} >= ({1'b0, seg} + (POS_W+1)'(d)));

  always_comb begin
    for (int j = 0; j < MAX_DELIM; j++) begin
      dbyte[j]    = delim_bytes[8*j +: 8];
      win_next[j] = (j == 0) ? src_word.byte_value : win[(j == 0) ? 0 : j-1];
      want_idx[j] = d - DLEN_W'(1) - DLEN_W'(j);
      hit[j]      = (DLEN_W'(j) >= d) ||
                    (win_next[j] == dbyte[want_idx[j][$clog2(MAX_DELIM)-1:0]]);
    end
  end

  assign match_hit = !saturated && (d != '0) && covered && (&hit);

  always_comb begin
    r_match.segment_start  = seg;
    r_match.segment_length = pos_inc - POS_W'(d) - seg;
    r_match.last_segment   = 1'b0;
    r_match.too_long       = ovf;

    r_empty = '0;
    r_empty.last_segment = 1'b1;

    ovf_next = ovf;
    pos_next = pos;
    seg_next = seg;
    if (saturated) begin
      ovf_next = 1'b1;
    end else begin
      pos_next = pos_inc;
      if (match_hit) begin
        seg_next = pos_inc;
      end
    end

    r_last.segment_start  = seg_next;
    r_last.segment_length = pos_next - seg_next;
    r_last.last_segment   = 1'b1;
    r_last.too_long       = ovf_next;

    entry = '0;
    push  = 1'b0;
    if (src_word.empty_string) begin
      entry.first = r_empty;
      push        = accept;
    end else if (match_hit) begin
      entry.first  = r_match;
      entry.second = r_last;
      entry.two    = src_word.last_byte;
      push         = accept;
    end else begin
      entry.first = r_last;
      push        = accept && src_word.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      seg <= '0;
      ovf <= 1'b0;
      for (int j = 0; j < MAX_DELIM; j++) begin
        win[j] <= '0;
      end
    end else if (accept) begin
      if (src_word.empty_string || src_word.last_byte) begin
        pos <= '0;
        seg <= '0;
        ovf <= 1'b0;
      end else begin
        pos <= pos_next;
        seg <= seg_next;
        ovf <= ovf_next;
      end
      if (!src_word.empty_string && !saturated) begin
        for (int j = 0; j < MAX_DELIM; j++) begin
          win[j] <= win_next[j];
        end
      end
    end
  end

endmodule

@@ rtl/core/dss_queue.sv @@
// Short queue of result entries between the front end and the output stage.
// Register storage, one push and one pop per cycle. Uses dss_pkg.
`timescale 1ns / 1ps

module dss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dss_pkg::dss_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                avail,
  output dss_pkg::dss_entry_t head_entry
);
  import dss_pkg::*;

  dss_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign avail      = (count != '0);
  assign head_entry = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/dss_back.sv @@
// Output stage: takes queue entries and sends their results one word a cycle
// unless stalled. Holds the second result of a two-result entry. Uses dss_pkg.
`timescale 1ns / 1ps

module dss_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  dss_pkg::dss_entry_t head_entry,
  output logic                pop,
  output logic                seg_valid,
  input  logic                seg_stall,
  output dss_pkg::seg_word_t  seg_word
);
  import dss_pkg::*;

  logic      has_second;
  seg_word_t second;
  logic      advance;

  assign advance = !seg_valid || !seg_stall;
  assign pop     = advance && !has_second && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid  <= 1'b0;
      has_second <= 1'b0;
    end else if (advance) begin
      if (has_second) begin
        seg_valid  <= 1'b1;
        has_second <= 1'b0;
      end else if (avail) begin
        seg_valid  <= 1'b1;
        has_second <= head_entry.two;
      end else begin
        seg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (has_second) begin
        seg_word <= second;
      end else if (avail) begin
        seg_word <= head_entry.first;
        second   <= head_entry.second;
      end
    end
  end

endmodule

@@ rtl/core/dss_checker.sv @@
// Port-level checks on the splitter output channel, bound to the top level.
// Depends on dss_pkg and delimiter_string_splitter_assert.svh.
`timescale 1ns / 1ps
`include "delimiter_string_splitter_assert.svh"

module dss_checker (
  input logic               clk,
  input logic               rst,
  input logic               seg_valid,
  input logic               seg_stall,
  input dss_pkg::seg_word_t seg_word
);
  import dss_pkg::*;

  logic [POS_W:0] seg_end;

  assign seg_end = {1'b0, seg_word.segment_start} + {1'b0, seg_word.segment_length};

  `DSS_ASSERT_NXT(a_valid_hold, seg_valid && seg_stall, seg_valid)
  `DSS_ASSERT_NXT(a_word_hold, seg_valid && seg_stall, $stable(seg_word))
  `DSS_ASSERT_IMP(a_end_bound, seg_valid, seg_end <= (POS_W+1)'(MAX_STRING))
  `DSS_ASSERT_IMP(a_mid_no_ovf, seg_valid && !seg_word.last_segment, !seg_word.too_long)

endmodule

bind delimiter_string_splitter dss_checker u_dss_checker (.*);
